[rtl/swac_pkg.sv]
`timescale 1ns / 1ps
package swac_pkg;

	// action codes carried in tuser
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_CLOSE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_OVERLAP = 2'd0;
	localparam logic [1:0] REG_RETAIN  = 2'd1;
	localparam logic [1:0] REG_LIMIT   = 2'd2;

	localparam int CFG_BITS   = 24;
	localparam int LIMIT_BITS = 6;

	localparam logic [CFG_BITS-1:0]   OVERLAP_RESET = 24'd500000;
	localparam logic [CFG_BITS-1:0]   RETAIN_RESET  = 24'd1000000;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = 6'd32;

	// controls from the sequencer to the tail unit
	typedef struct packed {
		logic clear;
		logic append;
		logic load;
		logic step;
	} tail_ctl_t;

endpackage

[rtl/swac_ram.sv]
`timescale 1ns / 1ps
module swac_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/swac_tail.sv]
`timescale 1ns / 1ps
module swac_tail #(
	parameter int TAIL_WORDS   = 8,
	parameter int WORD_ID_BITS = 32,
	parameter int MAX_WORDS    = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swac_pkg::tail_ctl_t                ctl,
	input  logic [WORD_ID_BITS-1:0]            app_id,
	input  logic [WORD_ID_BITS-1:0]            cur_id,
	input  logic [$clog2(MAX_WORDS+1)-1:0]     step_idx,
	input  logic [$clog2(TAIL_WORDS+1)-1:0]    limit,
	output logic [$clog2(TAIL_WORDS+1)-1:0]    tail_count,
	output logic [$clog2(TAIL_WORDS+1)-1:0]    match_len
);
	import swac_pkg::*;
	localparam int TCW = $clog2(TAIL_WORDS+1);

	// tail_q[0] is the newest committed id
	logic [WORD_ID_BITS-1:0] tail_q [TAIL_WORDS];
	logic [WORD_ID_BITS-1:0] win_q  [TAIL_WORDS];
	logic [TAIL_WORDS-1:0]   match_q;
	logic [TCW-1:0]          cnt_q;

	// count of held ids, saturating at the tail depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else if (ctl.append && int'(cnt_q) < TAIL_WORDS) begin
			cnt_q <= cnt_q + TCW'(1);
		end
	end

	// id shift line, oldest falls off the end
	always_ff @(posedge clk) begin
		if (ctl.append) begin
			for (int k = TAIL_WORDS - 1; k > 0; k--) begin
				tail_q[k] <= tail_q[k-1];
			end
			tail_q[0] <= app_id;
		end
	end

	// candidate n reads window slot n-1, shifted up one slot per step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int k = 0; k < TAIL_WORDS; k++) begin
				win_q[k] <= tail_q[k];
			end
			match_q <= '1;
		end else if (ctl.step) begin
			for (int k = 0; k < TAIL_WORDS; k++) begin
				if (k + 1 > int'(step_idx) && win_q[k] != cur_id) begin
					match_q[k] <= 1'b0;
				end
			end
			for (int k = TAIL_WORDS - 1; k > 0; k--) begin
				win_q[k] <= win_q[k-1];
			end
			win_q[0] <= win_q[0];
		end
	end

	// longest surviving candidate within the limit
	always_comb begin
		match_len = '0;
		for (int k = 0; k < TAIL_WORDS; k++) begin
			if (match_q[k] && k + 1 <= int'(limit)) begin
				match_len = TCW'(k + 1);
			end
		end
	end

	assign tail_count = cnt_q;
endmodule

[rtl/streaming_word_agreement_commit.sv]
`timescale 1ns / 1ps
// push and clear words keep the block idle; it is ready again the next cycle
// close walks the overlap words, scans the previous hypothesis if there is one,
// then emits and copies words; each word visit is a read state and then a compare
// or write state (registered memory read), and emitting waits while the output stalls
// committed words leave through one output register, each after its own memory read
// arst_n clears counts, tail, commit end (-1) and registers; word memories hold garbage
module streaming_word_agreement_commit #(
	parameter int MAX_WORDS    = 32,
	parameter int TAIL_WORDS   = 8,
	parameter int TIME_BITS    = 48,
	parameter int WORD_ID_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// word_id, start_us, end_us, zero fill
	input  logic [((WORD_ID_BITS+2*TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
	// action
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_word_id, out_start_us, out_end_us, zero fill
	output logic [((WORD_ID_BITS+2*TIME_BITS+7)/8)*8-1:0] m_axis_tdata,
	// last_of_commit
	output logic m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [swac_pkg::CFG_BITS-1:0] cfg_data
);
	import swac_pkg::*;

	localparam int EW  = WORD_ID_BITS + 2*TIME_BITS;
	localparam int DW  = ((EW + 7) / 8) * 8;
	localparam int AW  = $clog2(MAX_WORDS);
	localparam int CW  = $clog2(MAX_WORDS+1);
	localparam int TCW = $clog2(TAIL_WORDS+1);
	localparam int LW  = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_OVL_RD   = 10'b0000000010,
		ST_OVL_CMP  = 10'b0000000100,
		ST_DECIDE   = 10'b0000001000,
		ST_SCAN_RD  = 10'b0000010000,
		ST_SCAN_CMP = 10'b0000100000,
		ST_EMIT_RD  = 10'b0001000000,
		ST_EMIT_WR  = 10'b0010000000,
		ST_COPY_RD  = 10'b0100000000,
		ST_COPY_WR  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [CFG_BITS-1:0]   overlap_q, retain_q;
	logic [LIMIT_BITS-1:0] limit_q;

	logic [CW-1:0] cur_cnt_q, prev_cnt_q, off_q, n_q, conf_q, cap_q, idx_q;
	logic [TCW-1:0] lim_q;
	logic use_ovl_q;
	logic [TIME_BITS-1:0] first_start_q, lce_q;
	logic has_comm_q;

	// input fields
	logic [WORD_ID_BITS-1:0] in_id;
	logic [TIME_BITS-1:0]    in_start, in_end;
	assign in_id    = s_axis_tdata[WORD_ID_BITS-1:0];
	assign in_start = s_axis_tdata[WORD_ID_BITS+TIME_BITS-1:WORD_ID_BITS];
	assign in_end   = s_axis_tdata[EW-1:WORD_ID_BITS+TIME_BITS];

	logic in_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// memories
	logic          cur_we, prev_we;
	logic [AW-1:0] cur_raddr, prev_raddr;
	logic [EW-1:0] cur_rdata, prev_rdata;
	logic [CW-1:0] cur_addr_full;

	always_comb begin
		cur_addr_full = idx_q;
		case (state_q)
			ST_OVL_RD, ST_OVL_CMP:    cur_addr_full = idx_q;
			ST_SCAN_RD, ST_SCAN_CMP,
			ST_EMIT_RD, ST_EMIT_WR:   cur_addr_full = off_q + idx_q;
			ST_COPY_RD, ST_COPY_WR:   cur_addr_full = off_q + conf_q + idx_q;
			default:                  cur_addr_full = idx_q;
		endcase
	end
	assign cur_raddr  = cur_addr_full[AW-1:0];
	assign prev_raddr = idx_q[AW-1:0];

	// push acceptance checks
	logic signed [TIME_BITS:0] s_ext, e_ext, lce_ext, ret_ext, diff, adist;
	logic push_ok;
	assign s_ext   = $signed({in_start[TIME_BITS-1], in_start});
	assign e_ext   = $signed({in_end[TIME_BITS-1], in_end});
	assign lce_ext = $signed({lce_q[TIME_BITS-1], lce_q});
	assign ret_ext = $signed({{(TIME_BITS+1-CFG_BITS){1'b0}}, retain_q});
	assign diff    = lce_ext - s_ext;
	assign push_ok = (in_id != '0) && !in_start[TIME_BITS-1] && (e_ext >= s_ext)
		&& (int'(cur_cnt_q) < MAX_WORDS) && !(has_comm_q && diff >= ret_ext);
	assign cur_we  = in_acc && (s_axis_tuser == ACT_PUSH) && push_ok;

	swac_ram #(.WIDTH(EW), .DEPTH(MAX_WORDS)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_cnt_q[AW-1:0]),
		.wdata({in_end, in_start, in_id}), .raddr(cur_raddr), .rdata(cur_rdata)
	);

	assign prev_we = (state_q == ST_COPY_WR);
	swac_ram #(.WIDTH(EW), .DEPTH(MAX_WORDS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(idx_q[AW-1:0]),
		.wdata(cur_rdata), .raddr(prev_raddr), .rdata(prev_rdata)
	);

	// overlap window test on the first start
	logic signed [TIME_BITS:0] fs_ext, fdiff;
	logic ovl_ok;
	logic [TCW-1:0] tail_cnt, match_len;
	logic [CW-1:0] lim_c;
	assign fs_ext = $signed({1'b0, first_start_q});
	assign fdiff  = fs_ext - lce_ext;
	assign adist  = fdiff[TIME_BITS] ? -fdiff : fdiff;
	assign ovl_ok = (cur_cnt_q != '0) && has_comm_q && (tail_cnt != '0)
		&& (adist <= $signed({{(TIME_BITS+1-CFG_BITS){1'b0}}, overlap_q}));
	assign lim_c  = (int'(cur_cnt_q) < int'(tail_cnt)) ? cur_cnt_q : CW'(tail_cnt);

	// tail unit
	tail_ctl_t tctl;
	logic out_load;
	assign out_load = (state_q == ST_EMIT_WR) && (!m_axis_tvalid || m_axis_tready);
	always_comb begin
		tctl.clear  = in_acc && (s_axis_tuser == ACT_CLEAR);
		tctl.append = out_load;
		tctl.load   = in_acc && (s_axis_tuser == ACT_CLOSE) && ovl_ok;
		tctl.step   = (state_q == ST_OVL_CMP);
	end

	swac_tail #(.TAIL_WORDS(TAIL_WORDS), .WORD_ID_BITS(WORD_ID_BITS),
		.MAX_WORDS(MAX_WORDS)) u_tail (
		.clk(clk), .arst_n(arst_n), .ctl(tctl),
		.app_id(cur_rdata[WORD_ID_BITS-1:0]), .cur_id(cur_rdata[WORD_ID_BITS-1:0]),
		.step_idx(idx_q), .limit(lim_q), .tail_count(tail_cnt), .match_len(match_len)
	);

	// decision values
	logic [CW-1:0] off_c, n_c;
	logic [LW-1:0] cap_c;
	assign off_c = use_ovl_q ? CW'(match_len) : '0;
	assign n_c   = cur_cnt_q - off_c;
	always_comb begin
		cap_c = LW'(prev_cnt_q);
		if (LW'(n_c) < cap_c) cap_c = LW'(n_c);
		if (LW'(limit_q) < cap_c) cap_c = LW'(limit_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_q <= OVERLAP_RESET;
			retain_q  <= RETAIN_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OVERLAP: overlap_q <= cfg_data;
				REG_RETAIN:  retain_q  <= cfg_data;
				REG_LIMIT:   limit_q   <= cfg_data[LIMIT_BITS-1:0];
				default:     ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_cnt_q  <= '0;
			prev_cnt_q <= '0;
			lce_q      <= '1;
			has_comm_q <= 1'b0;
			use_ovl_q  <= 1'b0;
			idx_q      <= '0;
			off_q      <= '0;
			n_q        <= '0;
			conf_q     <= '0;
			cap_q      <= '0;
			lim_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_axis_tuser)
							ACT_PUSH: begin
								if (push_ok) cur_cnt_q <= cur_cnt_q + CW'(1);
							end
							ACT_CLOSE: begin
								use_ovl_q <= ovl_ok;
								lim_q     <= TCW'(lim_c);
								idx_q     <= '0;
								state_q   <= ovl_ok ? ST_OVL_RD : ST_DECIDE;
							end
							ACT_CLEAR: begin
								cur_cnt_q  <= '0;
								prev_cnt_q <= '0;
								lce_q      <= '1;
								has_comm_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_OVL_RD: state_q <= ST_OVL_CMP;
				ST_OVL_CMP: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= (int'(idx_q) + 1 >= int'(lim_q)) ? ST_DECIDE : ST_OVL_RD;
				end
				ST_DECIDE: begin
					off_q  <= off_c;
					n_q    <= n_c;
					conf_q <= '0;
					cap_q  <= CW'(cap_c);
					idx_q  <= '0;
					if (prev_cnt_q == '0 || cap_c == '0) state_q <= ST_COPY_RD;
					else state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: state_q <= ST_SCAN_CMP;
				ST_SCAN_CMP: begin
					if (prev_rdata[WORD_ID_BITS-1:0] == cur_rdata[WORD_ID_BITS-1:0]) begin
						if (idx_q + CW'(1) >= cap_q) begin
							conf_q  <= idx_q + CW'(1);
							idx_q   <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= ST_SCAN_RD;
						end
					end else begin
						conf_q  <= idx_q;
						idx_q   <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					if (idx_q == conf_q) begin
						idx_q   <= '0;
						state_q <= ST_COPY_RD;
					end else begin
						state_q <= ST_EMIT_WR;
					end
				end
				ST_EMIT_WR: begin
					if (out_load) begin
						lce_q      <= cur_rdata[EW-1:WORD_ID_BITS+TIME_BITS];
						has_comm_q <= 1'b1;
						idx_q      <= idx_q + CW'(1);
						state_q    <= ST_EMIT_RD;
					end
				end
				ST_COPY_RD: begin
					if (idx_q == n_q - conf_q) begin
						prev_cnt_q <= n_q - conf_q;
						cur_cnt_q  <= '0;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_COPY_WR;
					end
				end
				ST_COPY_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= ST_COPY_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// start of the first kept word
	always_ff @(posedge clk) begin
		if (cur_we && cur_cnt_q == '0) begin
			first_start_q <= in_start;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= DW'(cur_rdata);
			m_axis_tlast <= (idx_q + CW'(1) == conf_q);
		end
	end
endmodule

[rtl/swac_checker.sv]
`timescale 1ns / 1ps
module swac_checker #(
	parameter int DW = 128
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_axis_tvalid,
	input logic          s_axis_tready,
	input logic [1:0]    s_axis_tuser,
	input logic          m_axis_tvalid,
	input logic          m_axis_tready,
	input logic [DW-1:0] m_axis_tdata,
	input logic          m_axis_tlast
);
	import swac_pkg::*;

	// a stalled word holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// a push never starts an output word
	a_push_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_PUSH |=> !$rose(m_axis_tvalid))
		else $error("output word after a push");

	// a clear never starts an output word
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_CLEAR |=> !$rose(m_axis_tvalid))
		else $error("output word after a clear");

	// a close keeps the input side busy
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_CLOSE |=> !s_axis_tready)
		else $error("input ready right after a close");
endmodule

bind streaming_word_agreement_commit swac_checker #(.DW(DW)) u_swac_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
	import swac_pkg::*;

	localparam int MAXW     = 32;
	localparam int TAILW    = 8;
	localparam int LIMIT    = 600000;
	localparam int SETTLE   = 300;

	typedef struct {
		logic [31:0] id;
		longint      t_start;
		longint      t_end;
		logic        last;
	} commit_word_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	streaming_word_agreement_commit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// agreement mirror
	logic [23:0] overlap_win, retain_win;
	logic [5:0]  commit_limit;
	logic [31:0] cur_id [MAXW];
	longint      cur_s [MAXW], cur_e [MAXW];
	int          cur_n;
	logic [31:0] prev_id [MAXW];
	longint      prev_s [MAXW], prev_e [MAXW];
	int          prev_n;
	logic [31:0] tail_id [TAILW];
	int          tail_n;
	longint      commit_end;
	bit          committed;

	commit_word_t pending_commits[$];
	int  errors;
	int  cycles;
	bit  quiet;
	bit  hold_out;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void clear_mirror();
		cur_n = 0;
		prev_n = 0;
		tail_n = 0;
		commit_end = -1;
		committed = 1'b0;
	endfunction

	function automatic longint sext48(logic [47:0] v);
		logic signed [47:0] sv;
		sv = v;
		return longint'(sv);
	endfunction

	function automatic void mirror_push(logic [31:0] id, longint s, longint e);
		if (cur_n >= MAXW || id == 0 || s < 0 || e < s)
			return;
		if (committed && commit_end - s >= longint'(retain_win))
			return;
		cur_id[cur_n] = id;
		cur_s[cur_n] = s;
		cur_e[cur_n] = e;
		cur_n++;
	endfunction

	// leading words repeating the end of the committed tail
	function automatic int tail_overlap();
		longint gap_us;
		int lim;
		bit hit;
		if (cur_n == 0 || !committed || tail_n == 0)
			return 0;
		gap_us = (cur_s[0] >= commit_end) ? cur_s[0] - commit_end : commit_end - cur_s[0];
		if (gap_us > longint'(overlap_win))
			return 0;
		lim = (cur_n < tail_n) ? cur_n : tail_n;
		for (int n = lim; n > 0; n--) begin
			hit = 1'b1;
			for (int i = 0; i < n; i++)
				if (tail_id[tail_n - n + i] != cur_id[i])
					hit = 1'b0;
			if (hit)
				return n;
		end
		return 0;
	endfunction

	function automatic void mirror_close();
		int off, n, agree, lim;
		commit_word_t w;
		off = tail_overlap();
		n = cur_n - off;
		if (prev_n == 0) begin
			for (int k = 0; k < n; k++) begin
				prev_id[k] = cur_id[off+k];
				prev_s[k] = cur_s[off+k];
				prev_e[k] = cur_e[off+k];
			end
			prev_n = n;
			cur_n = 0;
			return;
		end
		lim = (prev_n < n) ? prev_n : n;
		agree = 0;
		while (agree < lim && prev_id[agree] == cur_id[off+agree])
			agree++;
		if (agree > int'(commit_limit))
			agree = int'(commit_limit);
		for (int k = 0; k < agree; k++) begin
			w.id = cur_id[off+k];
			w.t_start = cur_s[off+k];
			w.t_end = cur_e[off+k];
			w.last = (k + 1 == agree);
			pending_commits.push_back(w);
			if (tail_n < TAILW) begin
				tail_id[tail_n] = w.id;
				tail_n++;
			end else begin
				for (int i = 0; i < TAILW - 1; i++)
					tail_id[i] = tail_id[i+1];
				tail_id[TAILW-1] = w.id;
			end
		end
		if (agree > 0) begin
			commit_end = cur_e[off+agree-1];
			committed = 1'b1;
		end
		for (int k = 0; k < n - agree; k++) begin
			prev_id[k] = cur_id[off+agree+k];
			prev_s[k] = cur_s[off+agree+k];
			prev_e[k] = cur_e[off+agree+k];
		end
		prev_n = n - agree;
		cur_n = 0;
	endfunction

	// send one word, update the mirror when it is taken
	task automatic send_word(logic [1:0] act, logic [31:0] id, logic [47:0] ts,
			logic [47:0] te);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = act;
		s_axis_tdata = {te, ts, id};
		do @(posedge clk); while (!s_axis_tready);
		case (act)
			ACT_PUSH:  mirror_push(id, sext48(ts), sext48(te));
			ACT_CLOSE: mirror_close();
			ACT_CLEAR: clear_mirror();
			default: ;
		endcase
	endtask

	task automatic push(logic [31:0] id, longint s, longint e);
		send_word(ACT_PUSH, id, s[47:0], e[47:0]);
	endtask

	task automatic close_hyp();
		send_word(ACT_CLOSE, $urandom, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_commits.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_OVERLAP: overlap_win = val;
			REG_RETAIN:  retain_win = val;
			REG_LIMIT:   commit_limit = val[5:0];
			default: ;
		endcase
	endtask

	// receiver with random stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = 1'b0;
			repeat (quiet ? 0 : $urandom_range(0, 13)) @(negedge clk);
			while (hold_out) @(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		commit_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_commits.size() == 0) begin
				$error("unexpected word id=%h", m_axis_tdata[31:0]);
				errors++;
			end else begin
				w = pending_commits.pop_front();
				if (m_axis_tdata[31:0] !== w.id) begin
					$error("out_word_id exp %h got %h", w.id, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[79:32] !== w.t_start[47:0]) begin
					$error("out_start_us exp %h got %h", w.t_start[47:0],
						m_axis_tdata[79:32]);
					errors++;
				end
				if (m_axis_tdata[127:80] !== w.t_end[47:0]) begin
					$error("out_end_us exp %h got %h", w.t_end[47:0],
						m_axis_tdata[127:80]);
					errors++;
				end
				if (m_axis_tlast !== w.last) begin
					$error("last_of_commit exp %b got %b", w.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// a hypothesis built from a running script of words
	logic [31:0] script_id [64];
	longint      script_s [64];

	task automatic new_script(longint base);
		for (int i = 0; i < 64; i++) begin
			script_id[i] = $urandom_range(1, 12);
			script_s[i] = base + i * $urandom_range(150000, 350000) / 1;
		end
		for (int i = 1; i < 64; i++)
			if (script_s[i] <= script_s[i-1])
				script_s[i] = script_s[i-1] + 1;
	endtask

	task automatic send_hyp(int from, int len, output int sent);
		int r;
		sent = 0;
		for (int i = from; i < from + len && i < 64; i++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				push($urandom_range(1, 12), script_s[i], script_s[i] + 100000);
			else if (r == 1)
				send_word(2'($urandom_range(0, 3)), $urandom, 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}));
			else
				push(script_id[i], script_s[i], script_s[i] + $urandom_range(0, 140000));
			sent++;
		end
		close_hyp();
		sent++;
	endtask

	task automatic run_script(int hyps, inout int items);
		int from, sent;
		new_script($urandom_range(0, 4000000));
		from = 0;
		for (int h = 0; h < hyps; h++) begin
			send_hyp(from, $urandom_range(1, 4), sent);
			items += sent;
			from += $urandom_range(0, 3);
		end
	endtask

	task automatic test_directed();
		// field extremes, invalid words, unused action, empty close
		close_hyp();
		push(32'hFFFF_FFFF, 0, 0);
		push(32'h0000_0001, 48'sh7FFF_FFFF_FFFE, 48'sh7FFF_FFFF_FFFF);
		push(32'h0, 10, 20);
		push(32'h5, -1, 20);
		push(32'h6, 100, 99);
		send_word(2'd3, 32'h7, 48'd1, 48'd2);
		close_hyp();
		push(32'hFFFF_FFFF, 0, 0);
		push(32'h0000_0001, 48'sh7FFF_FFFF_FFFE, 48'sh7FFF_FFFF_FFFF);
		push(32'h9, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
		close_hyp();
		// a repeat of the committed tail near the commit end is stripped
		push(32'h1, 48'sh7FFF_FFFF_FFFE, 48'sh7FFF_FFFF_FFFF);
		push(32'h9, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
		close_hyp();
		push(32'h9, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
		close_hyp();
		send_word(ACT_CLEAR, 32'h0, 48'd0, 48'd0);
		push(32'h3, 5, 6);
		close_hyp();
		push(32'h3, 5, 6);
		close_hyp();
		wait_drain();
	endtask

	// register extremes, each followed by a few agreement rounds
	task automatic test_registers();
		int items;
		logic [23:0] ov [4] = '{24'd0, 24'hFFFFFF, 24'd400000, 24'd0};
		logic [23:0] rt [4] = '{24'hFFFFFF, 24'd0, 24'd300000, 24'd1000000};
		logic [5:0]  lm [4] = '{6'd0, 6'd1, 6'd32, 6'd3};
		items = 0;
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_OVERLAP, ov[k]);
			write_reg(REG_RETAIN, rt[k]);
			write_reg(REG_LIMIT, {18'h0, lm[k]});
			send_word(ACT_CLEAR, 32'h0, 48'd0, 48'd0);
			run_script(2, items);
			wait_drain();
		end
		write_reg(REG_OVERLAP, OVERLAP_RESET);
		write_reg(REG_RETAIN, RETAIN_RESET);
		write_reg(REG_LIMIT, {18'h0, LIMIT_RESET});
	endtask

	task automatic test_random();
		int items;
		items = 0;
		while (items < 10) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				send_word(ACT_CLEAR, 32'h0, 48'd0, 48'd0);
			run_script($urandom_range(3, 6), items);
		end
		quiet = 1'b0;
		wait_drain();
	endtask

	// full buffers and the longest commit while the receiver is held off
	task automatic test_backpressure();
		fork
			begin
				hold_out = 1'b1;
				repeat (1500) @(posedge clk);
				hold_out = 1'b0;
			end
			begin
				send_word(ACT_CLEAR, 32'h0, 48'd0, 48'd0);
				for (int pass = 0; pass < 2; pass++) begin
					for (int i = 0; i < MAXW + 1; i++)
						push(i + 1, i * 1000, i * 1000 + 500);
					close_hyp();
				end
				// offered while the commit waits on the held receiver
				push(32'h40, 40000, 40500);
				close_hyp();
				@(negedge clk);
				s_axis_tvalid = 1'b0;
			end
		join
		wait_drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_out = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_PUSH;
		cfg_we = 1'b0;
		cfg_index = REG_OVERLAP;
		cfg_data = '0;
		overlap_win = OVERLAP_RESET;
		retain_win = RETAIN_RESET;
		commit_limit = LIMIT_RESET;
		clear_mirror();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_registers();
		test_random();
		if (pending_commits.size() != 0) begin
			$error("%0d committed words never arrived", pending_commits.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
rtl/swac_pkg.sv
rtl/swac_ram.sv
rtl/swac_tail.sv
rtl/streaming_word_agreement_commit.sv
rtl/swac_checker.sv
dv/tb.sv
